>>> rtl/core/spk_pkg.sv
// Shared types and constants for the Speck 128-bit block cipher core.
// No dependencies.
package spk_pkg;

    localparam int WORD_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int ROT_R     = 8;
    localparam int ROT_L     = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORDS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3      = 3'd5;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [WORD_W-1:0] left_word;
        logic [WORD_W-1:0] right_word;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] left_out;
        logic [WORD_W-1:0] right_out;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic blk_load;
        logic key_load;
        logic key_step;
        logic rd_en;
        logic rnd_step;
        logic out_load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic cfg_hit;
        logic nr_zero;
        logic nr_small;
    } t_dp_status;

endpackage

>>> rtl/core/spk_dp.sv
// Datapath: configuration registers, round key memory, key schedule and
// the shared forward/inverse round unit. Depends on spk_pkg.
module spk_dp #(
    parameter int MAX_ROUNDS = 34,
    parameter int CW         = $clog2(MAX_ROUNDS + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [spk_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [spk_pkg::WORD_W-1:0]      i_cfg_data,
    input  spk_pkg::t_in_item               i_in_item,
    input  spk_pkg::t_dp_cmd                i_cmd,
    input  logic [CW-1:0]                   i_idx,
    output spk_pkg::t_dp_status             o_status,
    output logic [CW-1:0]                   o_nr,
    output spk_pkg::t_out_item              o_out_item
);
    import spk_pkg::*;

    localparam int AW = $clog2(MAX_ROUNDS);

    logic [2:0]        r_kw;
    logic [5:0]        r_rounds;
    logic [WORD_W-1:0] r_key [4];

    logic [WORD_W-1:0] r_rk_mem [MAX_ROUNDS];
    logic [WORD_W-1:0] r_rk_rd;

    logic [WORD_W-1:0] r_s0, r_s1, r_s2, r_b;
    logic [WORD_W-1:0] r_x, r_y;
    logic              r_op;
    t_out_item         r_out;

    logic [CW-1:0]     w_nr;
    logic [1:0]        w_win;
    logic [WORD_W-1:0] w_rk0, w_i0, w_i1, w_i2;
    logic              w_we;
    logic [AW-1:0]     w_wa, w_ra;
    logic [WORD_W-1:0] w_wd;
    logic [WORD_W-1:0] w_sa, w_sb;
    logic [WORD_W-1:0] w_fx, w_fy, w_ix, w_iy;
    logic              w_cfg_hit;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v, input int n);
        rotr = (v >> n) | (v << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int n);
        rotl = (v << n) | (v >> (WORD_W - n));
    endfunction

    // effective settings
    always_comb begin
        if (CW'(r_rounds) > CW'(MAX_ROUNDS)) begin
            w_nr = CW'(MAX_ROUNDS);
        end else begin
            w_nr = CW'(r_rounds);
        end
    end

    // least significant used key word is round key 0, the rest seed the window
    always_comb begin
        case (r_kw)
            3'd0, 3'd1, 3'd2: begin
                w_win = 2'd1;
                w_rk0 = r_key[1];
                w_i0  = r_key[0];
                w_i1  = r_key[0];
                w_i2  = r_key[0];
            end
            3'd3: begin
                w_win = 2'd2;
                w_rk0 = r_key[2];
                w_i0  = r_key[1];
                w_i1  = r_key[0];
                w_i2  = r_key[0];
            end
            default: begin
                w_win = 2'd3;
                w_rk0 = r_key[3];
                w_i0  = r_key[2];
                w_i1  = r_key[1];
                w_i2  = r_key[0];
            end
        endcase
    end

    // config writes
    always_comb begin
        case (i_cfg_index)
            CFG_KEY_WORDS, CFG_ROUNDS, CFG_KEY0,
            CFG_KEY1, CFG_KEY2, CFG_KEY3: w_cfg_hit = 1'b1;
            default:                      w_cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw     <= 3'd2;
            r_rounds <= 6'd32;
            r_key[0] <= '0;
            r_key[1] <= '0;
            r_key[2] <= '0;
            r_key[3] <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY_WORDS: r_kw     <= i_cfg_data[2:0];
                CFG_ROUNDS:    r_rounds <= i_cfg_data[5:0];
                CFG_KEY0:      r_key[0] <= i_cfg_data;
                CFG_KEY1:      r_key[1] <= i_cfg_data;
                CFG_KEY2:      r_key[2] <= i_cfg_data;
                CFG_KEY3:      r_key[3] <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // schedule step: round function on (window head, last key), key = index
    assign w_sa = (rotr(r_s0, ROT_R) + r_b) ^ WORD_W'(i_idx);
    assign w_sb = rotl(r_b, ROT_L) ^ w_sa;

    // cipher rounds
    assign w_fx = (rotr(r_x, ROT_R) + r_y) ^ r_rk_rd;
    assign w_fy = rotl(r_y, ROT_L) ^ w_fx;
    assign w_iy = rotr(r_y ^ r_x, ROT_L);
    assign w_ix = rotl((r_x ^ r_rk_rd) - w_iy, ROT_R);

    // key memory
    assign w_we = i_cmd.key_load | i_cmd.key_step;
    assign w_wa = i_cmd.key_load ? '0 : AW'(i_idx + CW'(1));
    assign w_wd = i_cmd.key_load ? w_rk0 : w_sb;
    assign w_ra = (r_op == OP_DECRYPT) ? AW'(w_nr - CW'(1) - i_idx) : AW'(i_idx);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_rk_mem[w_wa] <= w_wd;
        end
        if (i_cmd.rd_en) begin
            r_rk_rd <= r_rk_mem[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_load) begin
            r_b  <= w_rk0;
            r_s0 <= w_i0;
            r_s1 <= w_i1;
            r_s2 <= w_i2;
        end else if (i_cmd.key_step) begin
            r_b <= w_sb;
            case (w_win)
                2'd1: r_s0 <= w_sa;
                2'd2: begin
                    r_s0 <= r_s1;
                    r_s1 <= w_sa;
                end
                default: begin
                    r_s0 <= r_s1;
                    r_s1 <= r_s2;
                    r_s2 <= w_sa;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.blk_load) begin
            r_op <= i_in_item.operation;
            r_x  <= i_in_item.left_word;
            r_y  <= i_in_item.right_word;
        end else if (i_cmd.rnd_step) begin
            if (r_op == OP_DECRYPT) begin
                r_x <= w_ix;
                r_y <= w_iy;
            end else begin
                r_x <= w_fx;
                r_y <= w_fy;
            end
        end
        if (i_cmd.out_load) begin
            r_out.left_out  <= r_x;
            r_out.right_out <= r_y;
        end
    end

    assign o_status.cfg_hit  = i_cfg_valid & w_cfg_hit;
    assign o_status.nr_zero  = (w_nr == '0);
    assign o_status.nr_small = (w_nr < CW'(2));
    assign o_nr              = w_nr;
    assign o_out_item        = r_out;

endmodule

>>> rtl/core/spk_ctrl.sv
// Controller: sequences key rebuild, round issue and result hand-off.
// Depends on spk_pkg.
module spk_ctrl #(
    parameter int MAX_ROUNDS = 34,
    parameter int CW         = $clog2(MAX_ROUNDS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  spk_pkg::t_dp_status  i_status,
    input  logic [CW-1:0]        i_nr,
    output spk_pkg::t_dp_cmd     o_cmd,
    output logic [CW-1:0]        o_idx
);
    import spk_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_KEY_LOAD = 6'b000010,
        ST_KEY_RUN  = 6'b000100,
        ST_PREP     = 6'b001000,
        ST_RUN      = 6'b010000,
        ST_FIN      = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_keys_ready, n_keys_ready;
    logic          r_out_valid, n_out_valid;
    logic          w_key_last, w_rnd_last;

    assign w_key_last = ((CW+1)'(r_cnt) + (CW+1)'(2)) == (CW+1)'(i_nr);
    assign w_rnd_last = (r_cnt + CW'(1)) == i_nr;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_keys_ready = r_keys_ready;
        o_cmd        = '0;
        o_idx        = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.blk_load = 1'b1;
                    n_state = r_keys_ready ? ST_PREP : ST_KEY_LOAD;
                end
            end
            ST_KEY_LOAD: begin
                o_cmd.key_load = 1'b1;
                n_cnt          = '0;
                if (i_status.nr_small) begin
                    n_keys_ready = 1'b1;
                    n_state      = ST_PREP;
                end else begin
                    n_state = ST_KEY_RUN;
                end
            end
            ST_KEY_RUN: begin
                o_cmd.key_step = 1'b1;
                n_cnt          = r_cnt + CW'(1);
                if (w_key_last) begin
                    n_keys_ready = 1'b1;
                    n_state      = ST_PREP;
                end
            end
            ST_PREP: begin
                // fetch the first round key; memory read is registered
                o_idx = '0;
                n_cnt = '0;
                if (i_status.nr_zero) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.rnd_step = 1'b1;
                o_idx          = r_cnt + CW'(1);
                n_cnt          = r_cnt + CW'(1);
                if (w_rnd_last) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // any write to a known register invalidates the round keys
        if (i_status.cfg_hit) begin
            n_keys_ready = 1'b0;
        end
    end

    assign n_out_valid = o_cmd.out_load | (r_out_valid & ~i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_keys_ready <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_keys_ready <= n_keys_ready;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/speck128_block_cipher.sv
// Speck 128-bit block cipher, one round per cycle on a shared round unit.
// One item at a time: a new input is accepted only in the idle state, once the
// previous item's rounds are done and its result is loaded into the output
// register; round keys come from a registered round key memory read. After a
// config write the first item also waits for the key rebuild.
// Reset (synchronous, active low) restores register defaults; keys rebuild on first item.
module speck128_block_cipher #(
    parameter int MAX_ROUNDS = 34
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [spk_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [spk_pkg::WORD_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  spk_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output spk_pkg::t_out_item              o_out_item
);
    import spk_pkg::*;

    localparam int CW = $clog2(MAX_ROUNDS + 1);

    t_dp_cmd       w_cmd;
    t_dp_status    w_status;
    logic [CW-1:0] w_idx;
    logic [CW-1:0] w_nr;

    assign o_cfg_ready = 1'b1;

    spk_ctrl #(
        .MAX_ROUNDS (MAX_ROUNDS),
        .CW         (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .i_nr        (w_nr),
        .o_cmd       (w_cmd),
        .o_idx       (w_idx)
    );

    spk_dp #(
        .MAX_ROUNDS (MAX_ROUNDS),
        .CW         (CW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .i_idx       (w_idx),
        .o_status    (w_status),
        .o_nr        (w_nr),
        .o_out_item  (o_out_item)
    );

endmodule
